// File: rtl/stlp_pkg.sv
// Shared types and constants of the strided tile load engine.
// Used by every module of the engine; depends on nothing else.
package stlp_pkg;

    localparam int INPUT_DEPTH  = 2048;
    localparam int WEIGHT_DEPTH = 1024;
    localparam int BLOCK_SIZE   = 16;

    localparam int INP_BEATS = BLOCK_SIZE / 4;
    localparam int WGT_BEATS = (BLOCK_SIZE * BLOCK_SIZE) / 4;

    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 96;
    localparam int PAD_W      = 21;
    localparam int ROWW_W     = 18;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_BEAT  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_READ  = 3'd1,
        ACT_DATA  = 3'd2,
        ACT_ZERO  = 3'd3,
        ACT_DONE  = 3'd4,
        ACT_SKIP  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_TOP      = 3'd1,
        PH_INP_ADDR = 3'd2,
        PH_RIGHT    = 3'd3,
        PH_INP_DATA = 3'd4,
        PH_BOTTOM   = 3'd5,
        PH_WGT_ADDR = 3'd6,
        PH_WGT_DATA = 3'd7
    } phase_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        is_weight;
        logic [31:0] src_tile;
        logic [15:0] dst_tile;
        logic [15:0] y_size;
        logic [15:0] x_size;
        logic [15:0] row_stride;
        logic [15:0] pad_counts;
        logic        ar_ready;
        logic [31:0] beat_data;
        logic        beat_last;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] read_addr;
        logic [5:0]  burst_len_minus_one;
        logic        to_weight_buffer;
        logic [10:0] buffer_index;
        logic [7:0]  byte_offset;
        logic [31:0] write_data;
        logic        busy_res;
    } result_t;

endpackage

// File: rtl/stlp_front.sv
// Front stage: takes input beats, unpacks and classifies them into items.
// Depends on stlp_pkg.
module stlp_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [stlp_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [1:0]                        in_user,
    input  logic                              in_last,
    output logic                              item_valid,
    input  logic                              item_ready,
    output stlp_pkg::item_t                   item
);

    logic            valid_reg;
    logic            valid_next;
    stlp_pkg::item_t item_reg;
    stlp_pkg::item_t item_next;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        item_next.cmd        = stlp_pkg::cmd_t'(in_user);
        item_next.is_weight  = in_data[0];
        item_next.src_tile   = in_data[32:1];
        item_next.dst_tile   = in_data[48:33];
        item_next.y_size     = in_data[64:49];
        item_next.x_size     = in_data[80:65];
        item_next.row_stride = in_data[96:81];
        item_next.pad_counts = in_data[112:97];
        item_next.ar_ready   = in_data[113];
        item_next.beat_data  = in_data[145:114];
        item_next.beat_last  = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/stlp_queue.sv
// Two-entry queue of classified items between the front and back stages.
// Depends on stlp_pkg.
module stlp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  stlp_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output stlp_pkg::item_t pop_item
);

    stlp_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/stlp_back.sv
// Back stage: the load sequencer that turns each item into one result.
// Depends on stlp_pkg.
module stlp_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [31:0]                       base_addr,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  stlp_pkg::item_t                   item,
    output logic                              res_valid,
    input  logic                              res_ready,
    output stlp_pkg::result_t                 res
);

    localparam logic [31:0] InpDepth  = 32'(stlp_pkg::INPUT_DEPTH);
    localparam logic [31:0] WgtDepth  = 32'(stlp_pkg::WEIGHT_DEPTH);
    localparam logic [31:0] InpTile   = 32'(stlp_pkg::BLOCK_SIZE);
    localparam logic [31:0] WgtTile   = 32'(stlp_pkg::BLOCK_SIZE * stlp_pkg::BLOCK_SIZE);
    localparam logic [6:0]  InpBeats  = 7'(stlp_pkg::INP_BEATS);
    localparam logic [6:0]  WgtBeats  = 7'(stlp_pkg::WGT_BEATS);
    localparam logic [5:0]  InpLenM1  = 6'(stlp_pkg::INP_BEATS - 1);
    localparam logic [5:0]  WgtLenM1  = 6'(stlp_pkg::WGT_BEATS - 1);

    stlp_pkg::phase_t  phase_reg, phase_next;
    logic              kind_reg, kind_next;
    logic [31:0]       tile_reg, tile_next;
    logic [31:0]       dram_reg, dram_next;
    logic [15:0]       row_reg, row_next;
    logic [15:0]       col_reg, col_next;
    logic [stlp_pkg::PAD_W-1:0] pad_reg, pad_next;
    logic              lpd_reg, lpd_next;
    logic [6:0]        beat_reg, beat_next;
    logic [7:0]        elem_reg, elem_next;
    logic [15:0]       x_reg, x_next;
    logic [15:0]       y_reg, y_next;
    logic [15:0]       stride_reg, stride_next;
    logic [15:0]       pads_reg, pads_next;
    logic [31:0]       base_lat_reg, base_lat_next;
    logic              out_valid_reg, out_valid_next;
    stlp_pkg::result_t out_reg, out_next;

    logic              take;
    logic              zero_wr;
    logic              req;
    logic              row_adv;
    logic [31:0]       depth;
    logic [stlp_pkg::ROWW_W-1:0] row_w;
    logic [stlp_pkg::ROWW_W-1:0] start_row_w;
    logic [31:0]       stride_gap;
    logic [6:0]        limit;

    assign item_ready = !out_valid_reg || res_ready;
    assign take       = item_valid && item_ready;
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        tile_next     = tile_reg;
        dram_next     = dram_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        pad_next      = pad_reg;
        lpd_next      = lpd_reg;
        beat_next     = beat_reg;
        elem_next     = elem_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        stride_next   = stride_reg;
        pads_next     = pads_reg;
        base_lat_next = base_lat_reg;
        out_next      = '0;
        out_next.action = stlp_pkg::ACT_NONE;
        zero_wr       = 1'b0;
        req           = 1'b0;
        row_adv       = 1'b0;
        limit         = '0;
        depth       = kind_reg ? WgtDepth : InpDepth;
        row_w       = {2'b00, pads_reg[7:4]} + {2'b00, x_reg} + {2'b00, pads_reg[3:0]};
        start_row_w = {2'b00, item.pad_counts[7:4]} + {2'b00, item.x_size}
                      + {2'b00, item.pad_counts[3:0]};
        stride_gap  = {16'd0, stride_reg} - {16'd0, x_reg};

        case (item.cmd)
            stlp_pkg::CMD_START:
            begin
                if (phase_reg == stlp_pkg::PH_IDLE)
                begin
                    if (item.is_weight && (item.x_size == '0 || item.y_size == '0))
                    begin
                        out_next.action = stlp_pkg::ACT_SKIP;
                    end
                    else
                    begin
                        kind_next     = item.is_weight;
                        x_next        = item.x_size;
                        y_next        = item.y_size;
                        stride_next   = item.row_stride;
                        pads_next     = item.pad_counts;
                        tile_next     = {16'd0, item.dst_tile};
                        row_next      = '0;
                        col_next      = '0;
                        beat_next     = '0;
                        elem_next     = '0;
                        lpd_next      = 1'b0;
                        base_lat_next = base_addr;
                        if (item.is_weight)
                        begin
                            dram_next  = item.src_tile * WgtTile;
                            pad_next   = '0;
                            phase_next = stlp_pkg::PH_WGT_ADDR;
                        end
                        else
                        begin
                            dram_next  = item.src_tile * InpTile;
                            pad_next   = stlp_pkg::PAD_W'({17'd0, item.pad_counts[15:12]}
                                                          * {3'd0, start_row_w});
                            phase_next = stlp_pkg::PH_TOP;
                        end
                    end
                end
            end

            stlp_pkg::CMD_TICK:
            begin
                // Top padding ran out: open the first row in the same tick.
                if (phase_next == stlp_pkg::PH_TOP && pad_next == '0)
                begin
                    pad_next   = stlp_pkg::PAD_W'(pads_reg[7:4]);
                    lpd_next   = 1'b0;
                    phase_next = stlp_pkg::PH_INP_ADDR;
                end
                if (phase_next == stlp_pkg::PH_TOP)
                begin
                    zero_wr = 1'b1;
                end
                else if (phase_next == stlp_pkg::PH_INP_ADDR)
                begin
                    if (row_reg >= y_reg)
                    begin
                        pad_next   = stlp_pkg::PAD_W'({17'd0, pads_reg[11:8]}
                                                      * {3'd0, row_w});
                        phase_next = stlp_pkg::PH_BOTTOM;
                    end
                    else
                    begin
                        if (col_reg == '0 && !lpd_next && pad_next == '0)
                        begin
                            lpd_next = 1'b1;
                        end
                        if (col_reg == '0 && !lpd_next)
                        begin
                            zero_wr = 1'b1;
                            if (pad_next == stlp_pkg::PAD_W'(1))
                            begin
                                lpd_next = 1'b1;
                            end
                        end
                        else if (col_reg < x_reg)
                        begin
                            req = 1'b1;
                        end
                        else
                        begin
                            pad_next   = stlp_pkg::PAD_W'(pads_reg[3:0]);
                            phase_next = stlp_pkg::PH_RIGHT;
                        end
                    end
                end
                else if (phase_next == stlp_pkg::PH_WGT_ADDR)
                begin
                    if (row_reg >= y_reg)
                    begin
                        out_next.action = stlp_pkg::ACT_DONE;
                        phase_next      = stlp_pkg::PH_IDLE;
                    end
                    else if (col_reg < x_reg)
                    begin
                        req = 1'b1;
                    end
                    else
                    begin
                        dram_next = dram_reg + stride_gap * WgtTile;
                        col_next  = '0;
                        row_next  = row_reg + 16'd1;
                    end
                end

                // Phases that may also be entered earlier in this tick.
                if (!zero_wr && !req)
                begin
                    if (phase_next == stlp_pkg::PH_BOTTOM)
                    begin
                        if (pad_next != '0)
                        begin
                            zero_wr = 1'b1;
                        end
                        else
                        begin
                            out_next.action = stlp_pkg::ACT_DONE;
                            phase_next      = stlp_pkg::PH_IDLE;
                        end
                    end
                    else if (phase_next == stlp_pkg::PH_RIGHT)
                    begin
                        zero_wr = (pad_next != '0);
                        row_adv = (pad_next <= stlp_pkg::PAD_W'(1));
                    end
                end

                if (zero_wr)
                begin
                    if (tile_reg < depth)
                    begin
                        out_next.action           = stlp_pkg::ACT_ZERO;
                        out_next.to_weight_buffer = kind_reg;
                        out_next.buffer_index     = tile_reg[10:0];
                    end
                    tile_next = tile_reg + 32'd1;
                    pad_next  = pad_next - stlp_pkg::PAD_W'(1);
                end

                if (row_adv)
                begin
                    dram_next  = dram_reg + stride_gap * InpTile;
                    col_next   = '0;
                    row_next   = row_reg + 16'd1;
                    pad_next   = stlp_pkg::PAD_W'(pads_reg[7:4]);
                    lpd_next   = 1'b0;
                    phase_next = stlp_pkg::PH_INP_ADDR;
                end

                if (req)
                begin
                    out_next.action           = stlp_pkg::ACT_READ;
                    out_next.read_addr        = base_lat_reg + dram_reg;
                    out_next.to_weight_buffer = kind_reg;
                    out_next.burst_len_minus_one =
                        (phase_reg == stlp_pkg::PH_WGT_ADDR) ? WgtLenM1 : InpLenM1;
                    if (item.ar_ready)
                    begin
                        beat_next  = '0;
                        elem_next  = '0;
                        phase_next = (phase_reg == stlp_pkg::PH_WGT_ADDR)
                                     ? stlp_pkg::PH_WGT_DATA : stlp_pkg::PH_INP_DATA;
                    end
                end
            end

            stlp_pkg::CMD_BEAT:
            begin
                if (phase_reg == stlp_pkg::PH_INP_DATA || phase_reg == stlp_pkg::PH_WGT_DATA)
                begin
                    limit = (phase_reg == stlp_pkg::PH_WGT_DATA) ? WgtBeats : InpBeats;
                    if (beat_reg < limit)
                    begin
                        if (tile_reg < depth)
                        begin
                            out_next.action           = stlp_pkg::ACT_DATA;
                            out_next.to_weight_buffer = kind_reg;
                            out_next.buffer_index     = tile_reg[10:0];
                            out_next.byte_offset      = elem_reg;
                            out_next.write_data       = item.beat_data;
                        end
                        dram_next = dram_reg + 32'd4;
                        elem_next = elem_reg + 8'd4;
                        beat_next = beat_reg + 7'd1;
                    end
                    // A last beat ends the tile even past the burst length.
                    if (item.beat_last)
                    begin
                        tile_next  = tile_reg + 32'd1;
                        col_next   = col_reg + 16'd1;
                        phase_next = (phase_reg == stlp_pkg::PH_INP_DATA)
                                     ? stlp_pkg::PH_INP_ADDR : stlp_pkg::PH_WGT_ADDR;
                    end
                end
            end

            default:
            begin
                out_next.action = stlp_pkg::ACT_NONE;
            end
        endcase

        out_next.busy_res = (phase_next != stlp_pkg::PH_IDLE);

        out_valid_next = out_valid_reg && !res_ready;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= stlp_pkg::PH_IDLE;
            kind_reg      <= 1'b0;
            tile_reg      <= '0;
            dram_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            pad_reg       <= '0;
            lpd_reg       <= 1'b0;
            beat_reg      <= '0;
            elem_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            stride_reg    <= '0;
            pads_reg      <= '0;
            base_lat_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg    <= phase_next;
                kind_reg     <= kind_next;
                tile_reg     <= tile_next;
                dram_reg     <= dram_next;
                row_reg      <= row_next;
                col_reg      <= col_next;
                pad_reg      <= pad_next;
                lpd_reg      <= lpd_next;
                beat_reg     <= beat_next;
                elem_reg     <= elem_next;
                x_reg        <= x_next;
                y_reg        <= y_next;
                stride_reg   <= stride_next;
                pads_reg     <= pads_next;
                base_lat_reg <= base_lat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/strided_tile_load_with_padding_unit.sv
// Top level of the strided tile load engine with zero padding.
// Depends on stlp_pkg, stlp_front, stlp_queue and stlp_back.
//
// Channel   Direction  Handshake             Carries
// s_axis    in         tvalid/tready         one command beat (start, tick, read data)
// m_axis    out        tvalid/tready         one result beat per command beat
// apb       in         psel/penable/pready   base_addr register at byte address 0
//
// Every accepted input beat yields exactly one result beat, in order. The
// engine sustains one beat per cycle while the sink is ready; a beat passes
// the front register, the two-entry queue and the sequencer's output
// register before its result is offered. The sequencer state updates once
// per accepted beat. Reset clears all control state and the base address.
// Either side may stall freely: the queue decouples front and back, and the
// output register holds a result until the sink takes it.
module strided_tile_load_with_padding_unit
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: is_weight[0], src_tile[32:1], dst_tile[48:33],
    // y_size[64:49], x_size[80:65], row_stride[96:81], pad_counts[112:97],
    // ar_ready[113], beat_data[145:114], zero fill above.
    input  logic [stlp_pkg::IN_DATA_W-1:0]    s_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tlast,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: read_addr[31:0], burst_len_minus_one[37:32],
    // buffer_index[48:38], byte_offset[56:49], write_data[88:57],
    // busy_res[89], zero fill above.
    output logic [stlp_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Fields from bit 0: action[2:0], to_weight_buffer[3].
    output logic [3:0]                        m_tuser,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam logic [2:0] AddrBase = 3'd0;

    logic              base_wr;
    logic [31:0]       base_reg;
    logic [31:0]       base_next;
    logic              fr_valid;
    logic              fr_ready;
    stlp_pkg::item_t   fr_item;
    logic              q_valid;
    logic              q_ready;
    stlp_pkg::item_t   q_item;
    stlp_pkg::result_t res;

    // Register file: the single base address register.
    assign pready    = 1'b1;
    assign base_wr   = psel && penable && pwrite && (paddr == AddrBase);
    assign base_next = base_wr ? pwdata : base_reg;
    assign prdata    = (paddr == AddrBase) ? base_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    stlp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_user    (s_tuser),
        .in_last    (s_tlast),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    stlp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    stlp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .base_addr  (base_reg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tuser = {res.to_weight_buffer, res.action};
    assign m_tdata = {6'd0, res.busy_res, res.write_data, res.byte_offset,
                      res.buffer_index, res.burst_len_minus_one, res.read_addr};

endmodule
